FILE: rtl/utt_pkg.sv
package utt_pkg;

    localparam int DATA_BITS_DEF  = 8;
    localparam int TICK_WIDTH_DEF = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] BIT_PERIOD_RST  = 16'd730;
    localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd366;
    localparam logic             RX_ENABLE_RST   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_PERIOD  = 2'd0,
        CFG_HALF_PERIOD = 2'd1,
        CFG_RX_ENABLE   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_START,
        RX_DATA,
        RX_STOP
    } t_rx_state;

    typedef enum logic [2:0] {
        TX_IDLE,
        TX_START,
        TX_DATA,
        TX_STOP1,
        TX_STOP2
    } t_tx_state;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_FALSE_START = 2'd1,
        ERR_FRAMING     = 2'd2
    } t_rx_err;

    typedef struct packed {
        logic    valid;
        t_rx_err err;
    } t_rx_flags;

    typedef struct packed {
        logic line;
        logic ready;
        logic done;
    } t_tx_flags;

endpackage

FILE: rtl/utt_in_if.sv
interface utt_in_if #(
    parameter int DATA_BITS = utt_pkg::DATA_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 rx_line;
    logic                 send_valid;
    logic [DATA_BITS-1:0] send_byte;
    logic                 send_last;

    modport source (
        output valid, rx_line, send_valid, send_byte, send_last,
        input  ready
    );

    modport sink (
        input  valid, rx_line, send_valid, send_byte, send_last,
        output ready
    );
endinterface

FILE: rtl/utt_out_if.sv
interface utt_out_if #(
    parameter int DATA_BITS = utt_pkg::DATA_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 tx_line;
    logic                 send_ready;
    logic                 send_done;
    logic                 recv_valid;
    logic [DATA_BITS-1:0] recv_byte;
    logic [1:0]           recv_error;

    modport source (
        output valid, tx_line, send_ready, send_done, recv_valid, recv_byte, recv_error,
        input  ready
    );

    modport sink (
        input  valid, tx_line, send_ready, send_done, recv_valid, recv_byte, recv_error,
        output ready
    );
endinterface

FILE: rtl/utt_timer.sv
module utt_timer #(
    parameter int TICK_WIDTH = utt_pkg::TICK_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic                     i_clear,
    input  logic [utt_pkg::CFG_W-1:0] i_target,
    output logic                     o_expire
);
    logic [TICK_WIDTH-1:0] r_ticks;
    logic [TICK_WIDTH-1:0] n_ticks;
    logic [TICK_WIDTH-1:0] w_inc;
    logic [TICK_WIDTH-1:0] w_target;

    assign w_inc    = r_ticks + TICK_WIDTH'(1);
    assign w_target = TICK_WIDTH'(i_target);
    assign o_expire = (w_inc >= w_target);

    always_comb begin
        if (i_clear || o_expire) begin
            n_ticks = '0;
        end else begin
            n_ticks = w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
        end else if (i_step) begin
            r_ticks <= n_ticks;
        end
    end
endmodule

FILE: rtl/utt_rx.sv
module utt_rx #(
    parameter int DATA_BITS  = utt_pkg::DATA_BITS_DEF,
    parameter int TICK_WIDTH = utt_pkg::TICK_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic                      i_line,
    input  logic                      i_enable,
    input  logic [utt_pkg::CFG_W-1:0] i_bit_period,
    input  logic [utt_pkg::CFG_W-1:0] i_half_period,
    output utt_pkg::t_rx_flags        o_flags,
    output logic [DATA_BITS-1:0]      o_byte
);
    localparam int CNT_W = $clog2(DATA_BITS);

    utt_pkg::t_rx_state r_state;
    utt_pkg::t_rx_state n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [DATA_BITS-1:0] r_shift;
    logic [DATA_BITS-1:0] n_shift;
    logic                 r_prev;

    logic                      w_clear;
    logic                      w_expire;
    logic [utt_pkg::CFG_W-1:0] w_target;

    assign w_target = (r_state == utt_pkg::RX_START) ? i_half_period : i_bit_period;

    utt_timer #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_timer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (i_step),
        .i_clear  (w_clear),
        .i_target (w_target),
        .o_expire (w_expire)
    );

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_shift       = r_shift;
        w_clear       = 1'b0;
        o_flags.valid = 1'b0;
        o_flags.err   = utt_pkg::ERR_NONE;
        o_byte        = '0;
        unique case (r_state)
            utt_pkg::RX_IDLE: begin
                if (i_enable && r_prev && !i_line) begin
                    n_state = utt_pkg::RX_START;
                    n_shift = '0;
                    w_clear = 1'b1;
                end
            end
            utt_pkg::RX_START: begin
                if (w_expire) begin
                    if (!i_line) begin
                        n_state = utt_pkg::RX_DATA;
                        n_cnt   = '0;
                    end else begin
                        n_state     = utt_pkg::RX_IDLE;
                        o_flags.err = utt_pkg::ERR_FALSE_START;
                    end
                end
            end
            utt_pkg::RX_DATA: begin
                if (w_expire) begin
                    n_shift = {i_line, r_shift[DATA_BITS-1:1]};
                    n_cnt   = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DATA_BITS - 1)) begin
                        n_state = utt_pkg::RX_STOP;
                    end
                end
            end
            utt_pkg::RX_STOP: begin
                if (w_expire) begin
                    if (i_line) begin
                        o_flags.valid = 1'b1;
                        o_byte        = r_shift;
                    end else begin
                        o_flags.err = utt_pkg::ERR_FRAMING;
                    end
                    n_state = utt_pkg::RX_IDLE;
                end
            end
            default: begin
                n_state = utt_pkg::RX_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utt_pkg::RX_IDLE;
            r_cnt   <= '0;
            r_shift <= '0;
            r_prev  <= 1'b1;
        end else if (i_step) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_prev  <= i_line;
        end
    end
endmodule

FILE: rtl/utt_tx.sv
module utt_tx #(
    parameter int DATA_BITS  = utt_pkg::DATA_BITS_DEF,
    parameter int TICK_WIDTH = utt_pkg::TICK_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic                      i_offer,
    input  logic [DATA_BITS-1:0]      i_byte,
    input  logic                      i_last,
    input  logic [utt_pkg::CFG_W-1:0] i_bit_period,
    output utt_pkg::t_tx_flags        o_flags
);
    localparam int CNT_W = $clog2(DATA_BITS);

    utt_pkg::t_tx_state r_state;
    utt_pkg::t_tx_state n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [DATA_BITS-1:0] r_shift;
    logic [DATA_BITS-1:0] n_shift;
    logic                 r_final;
    logic                 n_final;
    logic                 r_level;
    logic                 n_level;

    logic w_expire;
    logic w_ready;
    logic w_load;
    logic w_done;
    logic w_tstep;

    assign w_ready = (r_state == utt_pkg::TX_IDLE) ||
                     ((r_state == utt_pkg::TX_STOP2) && w_expire);
    assign w_load  = w_ready && i_offer;
    assign w_tstep = i_step && ((r_state != utt_pkg::TX_IDLE) || w_load);

    utt_timer #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_timer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_tstep),
        .i_clear  (w_load),
        .i_target (i_bit_period),
        .o_expire (w_expire)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_final = r_final;
        n_level = r_level;
        w_done  = 1'b0;
        unique case (r_state)
            utt_pkg::TX_IDLE: begin
            end
            utt_pkg::TX_START: begin
                if (w_expire) begin
                    n_level = r_shift[0];
                    n_shift = r_shift >> 1;
                    n_cnt   = '0;
                    n_state = utt_pkg::TX_DATA;
                end
            end
            utt_pkg::TX_DATA: begin
                if (w_expire) begin
                    if (r_cnt == CNT_W'(DATA_BITS - 1)) begin
                        n_level = 1'b1;
                        n_state = utt_pkg::TX_STOP1;
                    end else begin
                        n_level = r_shift[0];
                        n_shift = r_shift >> 1;
                        n_cnt   = r_cnt + CNT_W'(1);
                    end
                end
            end
            utt_pkg::TX_STOP1: begin
                if (w_expire) begin
                    n_level = 1'b1;
                    n_state = utt_pkg::TX_STOP2;
                end
            end
            utt_pkg::TX_STOP2: begin
                if (w_expire) begin
                    w_done  = r_final;
                    n_level = 1'b1;
                    n_state = utt_pkg::TX_IDLE;
                end
            end
            default: begin
                n_state = utt_pkg::TX_IDLE;
            end
        endcase
        if (w_load) begin
            n_state = utt_pkg::TX_START;
            n_level = 1'b0;
            n_shift = i_byte;
            n_final = i_last;
        end
    end

    assign o_flags.line  = n_level;
    assign o_flags.ready = w_ready;
    assign o_flags.done  = w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utt_pkg::TX_IDLE;
            r_cnt   <= '0;
            r_shift <= '0;
            r_final <= 1'b0;
            r_level <= 1'b1;
        end else if (i_step) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_final <= n_final;
            r_level <= n_level;
        end
    end
endmodule

FILE: rtl/uart_tick_transceiver.sv
// Tick-driven serial transceiver, one start bit, DATA_BITS data bits LSB
// first, one stop bit checked on receive and two stop bits sent.
// i_in carries one oversampling tick per word: the sampled receive line and
// the transmit offer (send_valid, send_byte, send_last). o_out returns one
// word per tick: the transmit line level after that tick, send_ready (the
// transmitter could take an offer), send_done, recv_valid, recv_byte and recv_error.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 bit period, 1 half period, 2 receiver enable); write only while idle.
// Output: a tick's result is registered and shows in the next cycle.
// Throughput: one tick per cycle while o_out is taken; receiver, transmitter
// and their tick counters each update ahead of the output register.
// Reset: receiver and transmitter go idle with both lines seen as high,
// registers return to 730, 366 and enabled, and the output register empties.
// Stall: when o_out is not taken, the output word holds and i_in.ready drops
// until it leaves; a new tick is taken in the same cycle the old result goes.
module uart_tick_transceiver #(
    parameter int DATA_BITS  = utt_pkg::DATA_BITS_DEF,
    parameter int TICK_WIDTH = utt_pkg::TICK_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    utt_in_if.sink                        i_in,
    utt_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [utt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [utt_pkg::CFG_W-1:0]     i_cfg_data
);
    logic [utt_pkg::CFG_W-1:0] r_bit_period;
    logic [utt_pkg::CFG_W-1:0] r_half_period;
    logic                      r_rx_enable;

    logic                 r_out_valid;
    logic                 r_tx_line;
    logic                 r_send_ready;
    logic                 r_send_done;
    logic                 r_recv_valid;
    logic [DATA_BITS-1:0] r_recv_byte;
    logic [1:0]           r_recv_error;

    logic                 w_step;
    utt_pkg::t_rx_flags   w_rx;
    logic [DATA_BITS-1:0] w_rx_byte;
    utt_pkg::t_tx_flags   w_tx;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_step     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period  <= utt_pkg::BIT_PERIOD_RST;
            r_half_period <= utt_pkg::HALF_PERIOD_RST;
            r_rx_enable   <= utt_pkg::RX_ENABLE_RST;
        end else if (i_cfg_we) begin
            unique case (utt_pkg::t_cfg_idx'(i_cfg_idx))
                utt_pkg::CFG_BIT_PERIOD:  r_bit_period  <= i_cfg_data;
                utt_pkg::CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                utt_pkg::CFG_RX_ENABLE:   r_rx_enable   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    utt_rx #(
        .DATA_BITS  (DATA_BITS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_line        (i_in.rx_line),
        .i_enable      (r_rx_enable),
        .i_bit_period  (r_bit_period),
        .i_half_period (r_half_period),
        .o_flags       (w_rx),
        .o_byte        (w_rx_byte)
    );

    utt_tx #(
        .DATA_BITS  (DATA_BITS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_offer      (i_in.send_valid),
        .i_byte       (i_in.send_byte),
        .i_last       (i_in.send_last),
        .i_bit_period (r_bit_period),
        .o_flags      (w_tx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_tx_line    <= w_tx.line;
            r_send_ready <= w_tx.ready;
            r_send_done  <= w_tx.done;
            r_recv_valid <= w_rx.valid;
            r_recv_byte  <= w_rx_byte;
            r_recv_error <= w_rx.err;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.tx_line    = r_tx_line;
    assign o_out.send_ready = r_send_ready;
    assign o_out.send_done  = r_send_done;
    assign o_out.recv_valid = r_recv_valid;
    assign o_out.recv_byte  = r_recv_byte;
    assign o_out.recv_error = r_recv_error;
endmodule

FILE: rtl/utt_checker.sv
module utt_checker #(
    parameter int DATA_BITS = utt_pkg::DATA_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic                 i_tx_line,
    input logic                 i_send_ready,
    input logic                 i_send_done,
    input logic                 i_recv_valid,
    input logic [DATA_BITS-1:0] i_recv_byte,
    input logic [1:0]           i_recv_error
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tx_line) &&
        $stable(i_recv_byte) && $stable(i_recv_error) && $stable(i_send_done))
        else $error("output word changed while stalled");

    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output register");

    a_recv_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_recv_valid ? (i_recv_error == utt_pkg::ERR_NONE)
                                      : (i_recv_byte == '0)))
        else $error("receive word inconsistent");

    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_send_done |-> i_send_ready)
        else $error("send_done without send_ready");
endmodule

bind uart_tick_transceiver utt_checker #(
    .DATA_BITS (DATA_BITS)
) u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_tx_line    (o_out.tx_line),
    .i_send_ready (o_out.send_ready),
    .i_send_done  (o_out.send_done),
    .i_recv_valid (o_out.recv_valid),
    .i_recv_byte  (o_out.recv_byte),
    .i_recv_error (o_out.recv_error)
);
